### rtl/smev_pkg.sv
// ----------------------------------------------------------------------------
// Schedule makespan evaluator package
// Shared constants, field offsets and the types that connect the sequencer to
// its shared saturating add and compare unit.
// ----------------------------------------------------------------------------
package smev_pkg;

	localparam int JOB_W      = 6;
	localparam int MAX_JOBS   = 1 << JOB_W;
	localparam int TIME_WIDTH = 16;
	localparam int FIELD_W    = 16;
	localparam int DATA_W     = 32;

	localparam logic [DATA_W-1:0] SAT_MAX = '1;

	localparam int IN_JOB_LSB   = 0;
	localparam int IN_OTHER_LSB = IN_JOB_LSB + JOB_W;
	localparam int IN_HEAD_LSB  = IN_OTHER_LSB + JOB_W;
	localparam int IN_BODY_LSB  = IN_HEAD_LSB + FIELD_W;
	localparam int IN_TAIL_LSB  = IN_BODY_LSB + FIELD_W;
	localparam int IN_DELAY_LSB = IN_TAIL_LSB + FIELD_W;
	localparam int IN_USED_W    = IN_DELAY_LSB + FIELD_W;
	localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;
	localparam int IN_USER_W    = 3;
	localparam int OUT_DATA_W   = 3 * DATA_W;

	localparam logic [1:0] KIND_JOB   = 2'd0;
	localparam logic [1:0] KIND_DELAY = 2'd1;
	localparam logic [1:0] KIND_SCHED = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] c;
	} alu_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] mx;
		logic              gt;
	} alu_out_t;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] head;
		logic [TIME_WIDTH-1:0] body;
		logic [TIME_WIDTH-1:0] tail;
	} job_rec_t;

	function automatic logic [TIME_WIDTH-1:0] mask_time(input logic [FIELD_W-1:0] v);
		logic [DATA_W-1:0] wide;
		wide = DATA_W'(v);
		return wide[TIME_WIDTH-1:0];
	endfunction

endpackage

### rtl/schedule_makespan_evaluator_core.sv
// ----------------------------------------------------------------------------
// Schedule makespan evaluator core
// Evaluates a job sequence on one machine with heads, tails and delayed
// precedence, one shared saturating add and compare unit under a sequencer.
// ----------------------------------------------------------------------------
// A load transfer (job record or delay entry) leaves the sequencer idle, and the
// block is ready again right after it. A schedule transfer occupies the block
// while the fetch, head, start and fin states read the job record and work out
// the start and finish; then the sequencer walks the scheduled job's row of the
// delay matrix, one entry per cycle through the shared unit and the release
// memory port, and a final tail state forms the tail sum and the makespan. That
// final state lasts for as long as an earlier result still waits unaccepted
// in the output register. A new transfer may be accepted while the previous
// result still waits on the output register.
module schedule_makespan_evaluator_core import smev_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// job, other_job, head_time, body_time, tail_time, delay_time, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind, first
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// start_time, finish_plus_tail, makespan
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_HEAD  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_WALK  = 3'd5;
	localparam logic [2:0] ST_TAIL  = 3'd6;

	logic [2:0]            state_q;
	logic [JOB_W:0]        i_q;
	logic                  walk_v_s1;
	logic [JOB_W-1:0]      idx_s1;
	logic [MAX_JOBS-1:0]   rel_valid_q;
	logic [DATA_W-1:0]     running_time_q;
	logic [DATA_W-1:0]     makespan_q;
	logic [JOB_W-1:0]      j_q;
	logic                  last_q;
	logic [DATA_W-1:0]     ready_q;
	logic [DATA_W-1:0]     start_q;
	logic [DATA_W-1:0]     finish_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_last_q;

	job_rec_t              jobs_mem [MAX_JOBS];
	job_rec_t              job_rd_q;
	logic [TIME_WIDTH-1:0] delay_mem [MAX_JOBS*MAX_JOBS];
	logic [TIME_WIDTH-1:0] delay_rd_q;
	logic [DATA_W-1:0]     rel_mem [MAX_JOBS];
	logic [DATA_W-1:0]     rel_rd_q;

	logic                  accept;
	logic [1:0]            in_kind;
	logic                  in_first;
	logic [JOB_W-1:0]      in_job;
	logic [JOB_W-1:0]      in_other;
	logic [JOB_W-1:0]      rel_raddr;
	logic                  rel_we;
	logic                  out_free;
	alu_in_t               alu_op;
	alu_out_t              alu_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_kind       = s_axis_tuser[1:0];
	assign in_first      = s_axis_tuser[2];
	assign in_job        = s_axis_tdata[IN_JOB_LSB +: JOB_W];
	assign in_other      = s_axis_tdata[IN_OTHER_LSB +: JOB_W];
	assign out_free      = !m_valid_q || m_axis_tready;
	assign rel_raddr     = (state_q == ST_WALK) ? i_q[JOB_W-1:0] : j_q;
	assign rel_we        = (state_q == ST_WALK) && walk_v_s1 && (delay_rd_q != '0) &&
	                       (!rel_valid_q[idx_s1] || alu_res.gt);

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_JOB) begin
			jobs_mem[in_job] <= '{head: mask_time(s_axis_tdata[IN_HEAD_LSB +: FIELD_W]),
			                      body: mask_time(s_axis_tdata[IN_BODY_LSB +: FIELD_W]),
			                      tail: mask_time(s_axis_tdata[IN_TAIL_LSB +: FIELD_W])};
		end
		job_rd_q <= jobs_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_DELAY) begin
			delay_mem[{in_job, in_other}] <=
				mask_time(s_axis_tdata[IN_DELAY_LSB +: FIELD_W]);
		end
		delay_rd_q <= delay_mem[{j_q, i_q[JOB_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (rel_we) begin
			rel_mem[idx_s1] <= alu_res.y;
		end
		rel_rd_q <= rel_mem[rel_raddr];
	end

	always_comb begin
		alu_op = '0;
		unique case (state_q)
			ST_HEAD: begin
				alu_op.a = DATA_W'(job_rd_q.head);
				alu_op.c = rel_valid_q[j_q] ? rel_rd_q : '0;
			end
			ST_START: begin
				alu_op.a = ready_q;
				alu_op.c = running_time_q;
			end
			ST_FIN: begin
				alu_op.a = start_q;
				alu_op.b = DATA_W'(job_rd_q.body);
			end
			ST_WALK: begin
				alu_op.a = finish_q;
				alu_op.b = DATA_W'(delay_rd_q);
				alu_op.c = rel_rd_q;
			end
			ST_TAIL: begin
				alu_op.a = finish_q;
				alu_op.b = DATA_W'(job_rd_q.tail);
				alu_op.c = makespan_q;
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	smev_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			i_q            <= '0;
			walk_v_s1      <= 1'b0;
			rel_valid_q    <= '0;
			running_time_q <= '0;
			makespan_q     <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			if (state_q == ST_TAIL && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_kind == KIND_SCHED) begin
						if (in_first) begin
							rel_valid_q    <= '0;
							running_time_q <= '0;
							makespan_q     <= '0;
						end
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					running_time_q <= alu_res.y;
					i_q            <= '0;
					state_q        <= ST_WALK;
				end
				ST_WALK: begin
					if (!i_q[JOB_W]) begin
						i_q <= i_q + 1'b1;
					end
					walk_v_s1 <= !i_q[JOB_W];
					if (rel_we) begin
						rel_valid_q[idx_s1] <= 1'b1;
					end
					if (i_q[JOB_W] && !walk_v_s1) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (out_free) begin
						makespan_q <= alu_res.mx;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_kind == KIND_SCHED) begin
			j_q    <= in_job;
			last_q <= s_axis_tlast;
		end
		if (state_q == ST_HEAD) begin
			ready_q <= alu_res.mx;
		end
		if (state_q == ST_START) begin
			start_q <= alu_res.mx;
		end
		if (state_q == ST_FIN) begin
			finish_q <= alu_res.y;
		end
		idx_s1 <= i_q[JOB_W-1:0];
		if (state_q == ST_TAIL && out_free) begin
			m_data_q <= {alu_res.mx, alu_res.y, start_q};
			m_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

### rtl/smev_alu.sv
// ----------------------------------------------------------------------------
// Shared saturating add and compare unit
// Computes y = min(a + b, all ones), then compares y against c and returns
// the larger of the two. With b at zero it serves as a plain maximum.
// ----------------------------------------------------------------------------
module smev_alu import smev_pkg::*; (
	input  alu_in_t  op,
	output alu_out_t res
);

	logic [DATA_W:0] sum;

	always_comb begin
		sum    = {1'b0, op.a} + {1'b0, op.b};
		res.y  = sum[DATA_W] ? SAT_MAX : sum[DATA_W-1:0];
		res.gt = res.y > op.c;
		res.mx = res.gt ? res.y : op.c;
	end

endmodule

### rtl/smev_checker.sv
// ----------------------------------------------------------------------------
// Schedule makespan evaluator port checker
// Watches the ports of the core over time and is bound to the core.
// ----------------------------------------------------------------------------
module smev_checker import smev_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_USER_W-1:0]  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// A stalled result transfer keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A schedule transfer keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == KIND_SCHED |=> !s_axis_tready)
		else $error("ready after schedule transfer");

	// A load transfer never blocks the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] != KIND_SCHED |=> s_axis_tready)
		else $error("busy after load transfer");

	// The tail sum never precedes the start, and the makespan covers the tail sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[2*DATA_W-1:DATA_W] >= m_axis_tdata[DATA_W-1:0] &&
			m_axis_tdata[3*DATA_W-1:2*DATA_W] >= m_axis_tdata[2*DATA_W-1:DATA_W])
		else $error("result ordering violated");

endmodule

bind schedule_makespan_evaluator_core smev_checker u_smev_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
